@@ rtl/trls_pkg.sv @@
package trls_pkg;

    // default configuration
    localparam int DEPTH_DEF         = 32;
    localparam int PAYLOAD_WIDTH_DEF = 64;
    localparam int STREAMS_DEF       = 4;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int STREAM_W = 2;
    localparam int STAMP_W  = 32;
    localparam int LIMIT_W  = 6;
    localparam int KIND_W   = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_SAVE  = 2'd0;
    localparam logic [OP_W-1:0] OP_DUMP  = 2'd1;
    localparam logic [OP_W-1:0] OP_RANGE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RANGE = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic              latch;
        logic              save;
        logic              clear;
        logic              scan_init;
        logic              rd;
        logic              eval_range;
        logic              out_load;
        logic [KIND_W-1:0] out_kind;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            ok;
        logic            limit_zero;
        logic            hit;
        logic            scan_end;
        logic            count_hit;
    } sts_t;

endpackage

@@ rtl/timestamped_ring_log_store_top.sv @@
// Timestamped ring log store: STREAMS circular stores of DEPTH slots, each
// slot a 32-bit stamp and a payload word; a stamp of zero marks an empty slot.
// Input channel (in_valid/in_ready) takes one operation word: save, dump newest
// first, stamp range or clear. Output channel (out_valid/out_ready) returns
// result words; the final word of each operation carries last.
// Sequencing: a save or clear is acknowledged from S_ACK after S_START. A dump
// or range query sets up its scan in S_START, then steps through the stream's
// slots on the single read port of the slot memory, S_RD and S_EV for each
// slot, plus S_EMIT for each dump entry emitted and S_FINAL for the closing
// word. One operation is worked on at a time; in_ready is high whenever the
// controller is idle.
// The output word sits in a register, so a new operation is taken while the
// previous closing word still waits; a stalled receiver holds the scan at the
// next word to emit without losing it.
// Reset: write pointers return to zero and all slot valid bits clear at once,
// so every stamp reads as zero; a clear drops the valid bits the same way and
// keeps the pointers.
module timestamped_ring_log_store_top #(
    parameter int DEPTH         = trls_pkg::DEPTH_DEF,
    parameter int PAYLOAD_WIDTH = trls_pkg::PAYLOAD_WIDTH_DEF,
    parameter int STREAMS       = trls_pkg::STREAMS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [trls_pkg::OP_W-1:0]     operation,
    input  logic [trls_pkg::STREAM_W-1:0] stream,
    input  logic [trls_pkg::STAMP_W-1:0]  stamp,
    input  logic [PAYLOAD_WIDTH-1:0]      payload,
    input  logic [trls_pkg::LIMIT_W-1:0]  dump_limit,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [trls_pkg::KIND_W-1:0]   kind,
    output logic [trls_pkg::STAMP_W-1:0]  entry_stamp,
    output logic [PAYLOAD_WIDTH-1:0]      entry_payload,
    output logic [trls_pkg::LIMIT_W-1:0]  found,
    output logic [trls_pkg::STAMP_W-1:0]  oldest,
    output logic [trls_pkg::STAMP_W-1:0]  newest,
    output logic                          last
);
    import trls_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencing
    trls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // stores, scan and output register
    trls_dp #(
        .DEPTH         (DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
        .STREAMS       (STREAMS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .operation     (operation),
        .stream        (stream),
        .stamp         (stamp),
        .payload       (payload),
        .dump_limit    (dump_limit),
        .kind          (kind),
        .entry_stamp   (entry_stamp),
        .entry_payload (entry_payload),
        .found         (found),
        .oldest        (oldest),
        .newest        (newest),
        .last          (last)
    );

endmodule

@@ rtl/trls_dp.sv @@
module trls_dp #(
    parameter int DEPTH         = trls_pkg::DEPTH_DEF,
    parameter int PAYLOAD_WIDTH = trls_pkg::PAYLOAD_WIDTH_DEF,
    parameter int STREAMS       = trls_pkg::STREAMS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  trls_pkg::cmd_t                cmd,
    output trls_pkg::sts_t                sts,
    input  logic [trls_pkg::OP_W-1:0]     operation,
    input  logic [trls_pkg::STREAM_W-1:0] stream,
    input  logic [trls_pkg::STAMP_W-1:0]  stamp,
    input  logic [PAYLOAD_WIDTH-1:0]      payload,
    input  logic [trls_pkg::LIMIT_W-1:0]  dump_limit,
    output logic [trls_pkg::KIND_W-1:0]   kind,
    output logic [trls_pkg::STAMP_W-1:0]  entry_stamp,
    output logic [PAYLOAD_WIDTH-1:0]      entry_payload,
    output logic [trls_pkg::LIMIT_W-1:0]  found,
    output logic [trls_pkg::STAMP_W-1:0]  oldest,
    output logic [trls_pkg::STAMP_W-1:0]  newest,
    output logic                          last
);
    import trls_pkg::*;

    localparam int PW        = $clog2(DEPTH);
    localparam int MEM_DEPTH = STREAMS << PW;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int IW        = $clog2(DEPTH + 1);

    // latched input word
    logic [OP_W-1:0]          op_reg;
    logic [STREAM_W-1:0]      stream_reg;
    logic [STAMP_W-1:0]       stamp_reg;
    logic [PAYLOAD_WIDTH-1:0] payload_reg;
    logic [LIMIT_W-1:0]       limit_reg;

    // stores
    logic [STAMP_W-1:0]       stamp_mem [MEM_DEPTH];
    logic [PAYLOAD_WIDTH-1:0] pay_mem   [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]     valid_reg;
    logic [PW-1:0]            wp_reg    [STREAMS];

    // scan state
    logic [PW-1:0]            scan_reg;
    logic [IW-1:0]            idx_reg;
    logic [LIMIT_W-1:0]       count_reg;
    logic [STAMP_W-1:0]       lo_reg;
    logic [STAMP_W-1:0]       hi_reg;
    logic [STAMP_W-1:0]       rd_stamp_reg;
    logic [PAYLOAD_WIDTH-1:0] rd_pay_reg;
    logic                     rd_valid_reg;

    logic [PW-1:0]            wp_cur;
    logic [PW-1:0]            wp_next;
    logic [PW-1:0]            scan_next;
    logic [STREAM_W+PW-1:0]   wr_full;
    logic [STREAM_W+PW-1:0]   rd_full;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr;
    logic [STAMP_W-1:0]       hit_stamp;

    // latch the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg      <= operation;
            stream_reg  <= stream;
            stamp_reg   <= stamp;
            payload_reg <= payload;
            limit_reg   <= dump_limit;
        end
    end

    // write pointer of the selected stream
    always_comb
    begin
        wp_cur = '0;
        for (int i = 0; i < STREAMS; i++)
        begin
            if (stream_reg == STREAM_W'(i))
            begin
                wp_cur = wp_reg[i];
            end
        end
    end

    assign wp_next   = (wp_cur == PW'(DEPTH - 1)) ? '0 : wp_cur + 1'b1;
    assign scan_next = (scan_reg == '0) ? PW'(DEPTH - 1) : scan_reg - 1'b1;
    assign wr_full   = {stream_reg, wp_cur};
    assign rd_full   = {stream_reg, scan_next};
    assign wr_addr   = wr_full[AW-1:0];
    assign rd_addr   = rd_full[AW-1:0];
    assign hit_stamp = rd_valid_reg ? rd_stamp_reg : '0;

    // slot memories
    always_ff @(posedge clk)
    begin
        if (cmd.save)
        begin
            stamp_mem[wr_addr] <= stamp_reg;
            pay_mem[wr_addr]   <= payload_reg;
        end
        if (cmd.rd)
        begin
            rd_stamp_reg <= stamp_mem[rd_addr];
            rd_pay_reg   <= pay_mem[rd_addr];
        end
    end

    // slot valid bits and write pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            for (int i = 0; i < STREAMS; i++)
            begin
                wp_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.clear)
            begin
                valid_reg <= '0;
            end
            if (cmd.save)
            begin
                valid_reg[wr_addr] <= 1'b1;
                for (int i = 0; i < STREAMS; i++)
                begin
                    if (stream_reg == STREAM_W'(i))
                    begin
                        wp_reg[i] <= wp_next;
                    end
                end
            end
            if (cmd.rd)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // scan pointer, counters and range accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg  <= '0;
            idx_reg   <= '0;
            count_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
        end
        else
        begin
            if (cmd.scan_init)
            begin
                scan_reg  <= wp_cur;
                idx_reg   <= '0;
                count_reg <= '0;
                lo_reg    <= '0;
                hi_reg    <= '0;
            end
            if (cmd.rd)
            begin
                scan_reg <= scan_next;
                idx_reg  <= idx_reg + 1'b1;
            end
            if (cmd.eval_range)
            begin
                if (hit_stamp != '0 && (lo_reg == '0 || hit_stamp < lo_reg))
                begin
                    lo_reg <= hit_stamp;
                end
                if (hit_stamp > hi_reg)
                begin
                    hi_reg <= hit_stamp;
                end
            end
            if (cmd.out_load && cmd.out_kind == KIND_ENTRY)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            kind          <= cmd.out_kind;
            entry_stamp   <= (cmd.out_kind == KIND_ENTRY) ? hit_stamp : '0;
            entry_payload <= (cmd.out_kind == KIND_ENTRY) ? rd_pay_reg : '0;
            found         <= (cmd.out_kind == KIND_DONE) ? count_reg : '0;
            oldest        <= (cmd.out_kind == KIND_RANGE) ? lo_reg : '0;
            newest        <= (cmd.out_kind == KIND_RANGE) ? hi_reg : '0;
            last          <= (cmd.out_kind != KIND_ENTRY);
        end
    end

    // status
    assign sts.op         = op_reg;
    assign sts.ok         = ({1'b0, stream_reg} < (STREAM_W + 1)'(STREAMS));
    assign sts.limit_zero = (limit_reg == '0);
    assign sts.hit        = (hit_stamp != '0);
    assign sts.scan_end   = (idx_reg == IW'(DEPTH));
    assign sts.count_hit  = (({1'b0, count_reg} + 1'b1) == {1'b0, limit_reg});

    // an entry is only emitted while below the limit
    a_count_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && cmd.out_kind == KIND_ENTRY |-> count_reg < limit_reg)
        else $error("dump entry emitted at or beyond the limit");

    // the scan never runs past one lap of the stream
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IW'(DEPTH))
        else $error("scan index past stream depth");

    // smallest stamp never exceeds largest
    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg != '0 |-> lo_reg <= hi_reg)
        else $error("range accumulators out of order");

endmodule

@@ rtl/trls_ctrl.sv @@
module trls_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  trls_pkg::sts_t sts,
    output trls_pkg::cmd_t cmd
);
    import trls_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_ACK,
        S_RD,
        S_EV,
        S_EMIT,
        S_FINAL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // command decode and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.latch = in_valid;
                if (in_valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                unique case (sts.op)
                    OP_SAVE:
                    begin
                        cmd.save   = sts.ok;
                        state_next = S_ACK;
                    end
                    OP_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_ACK;
                    end
                    OP_DUMP:
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = (!sts.ok || sts.limit_zero) ? S_FINAL : S_RD;
                    end
                    default:
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = !sts.ok ? S_FINAL : S_RD;
                    end
                endcase
            end
            S_ACK:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_ACK;
                    state_next   = S_IDLE;
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EV;
            end
            S_EV:
            begin
                if (sts.op == OP_RANGE)
                begin
                    cmd.eval_range = 1'b1;
                    state_next     = sts.scan_end ? S_FINAL : S_RD;
                end
                else if (sts.hit)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = sts.scan_end ? S_FINAL : S_RD;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_ENTRY;
                    state_next   = (sts.count_hit || sts.scan_end) ? S_FINAL : S_RD;
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = (sts.op == OP_DUMP) ? KIND_DONE : KIND_RANGE;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // busy right after taking a word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice in a row");

    // output register is only overwritten once free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten before taken");

    // a dump entry is never the closing word
    a_entry_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && cmd.out_kind == KIND_ENTRY |=> state_reg != S_IDLE)
        else $error("returned to idle after a dump entry");

endmodule
